@@ rtl/core/pfba_pkg.sv @@
// Package with the shared types and codes of the page frame bitmap allocator.
package pfba_pkg;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_RESERVE = 2'd2;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NO_SPACE     = 2'd1;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [1:0] ST_RANGE        = 2'd3;

   localparam int unsigned MANAGED_RESET = 4096;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] frame_index;
      logic [12:0] run_length;
      logic [12:0] align_frames;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] base_frame;
      logic [12:0] frames_done;
      logic [12:0] free_count;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_CNT_EV,
      OP_CNT_FIN,
      OP_PREP,
      OP_ALLOC_EV,
      OP_ALLOC_OK,
      OP_MARK,
      OP_FREE_EV,
      OP_RES_EV,
      OP_SET_ST,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] st;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       len_zero;
      logic       dirty;
      logic       p_at_m;
      logic       p_last;
      logic       start_fits;
      logic       run_end;
      logic       count_done;
      logic       bit_used;
   } dp_status_type;

endpackage

@@ rtl/core/pfba_req_if.sv @@
// Request channel carrying one allocator request word.
interface pfba_req_if;
   logic                  valid;
   logic                  ready;
   pfba_pkg::req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/pfba_rsp_if.sv @@
// Response channel carrying one allocator result word.
interface pfba_rsp_if;
   logic                  valid;
   logic                  ready;
   pfba_pkg::rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/pfba_csr_if.sv @@
// Register write channel carrying the managed frame count.
interface pfba_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/page_frame_bitmap_allocator.sv @@
// Top level of the page frame bitmap allocator.
// After reset a clearing pass marks every frame free; no request word is taken during
// it. The used bitmap is a one-bit-wide memory with a registered read port, and every
// frame visit passes through a read state and an evaluation state, so rate is set by
// that single port. After reset or a managed_frames write, the next request first
// recounts free frames over every managed frame. An allocation probes frames for a
// free aligned run of run_length frames and then marks it; a free clears frames from
// frame_index one by one; a reserve marks the single frame at frame_index if it is
// free. One request is handled at a time; a finished result word waits in the output
// register while the next request is accepted.
module page_frame_bitmap_allocator #(
   parameter int unsigned FRAMES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   pfba_req_if.sink      req_port,
   pfba_rsp_if.source    rsp_port,
   pfba_csr_if.sink      csr_port
);

   pfba_pkg::dp_cmd_type    cmd;
   pfba_pkg::dp_status_type status;

   assign csr_port.ready = 1'b1;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready)
   );

   pfba_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_port.payload),
      .csr_we   (csr_port.valid),
      .csr_data (csr_port.data),
      .rsp_word (rsp_port.payload)
   );

endmodule

@@ rtl/core/pfba_datapath.sv @@
// Datapath of the allocator: used bitmap memory, frame pointer, counters and result register.
module pfba_datapath #(
   parameter int unsigned FRAMES = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pfba_pkg::dp_cmd_type     cmd,
   output pfba_pkg::dp_status_type  status,
   input  pfba_pkg::req_word_type   req_word,
   input  logic                     csr_we,
   input  logic [12:0]              csr_data,
   output pfba_pkg::rsp_word_type   rsp_word
);

   localparam int unsigned AW = $clog2(FRAMES);
   localparam int unsigned XW = $clog2(FRAMES + 2 * (1 << 13));

   logic                   mem [FRAMES];
   logic                   rd_ff;
   logic                   we;
   logic                   wd;

   logic [12:0]            managed_ff, managed_in;
   logic                   dirty_ff, dirty_in;
   logic [XW-1:0]          p_ff, p_in;
   logic [XW-1:0]          start_ff, start_in;
   logic [12:0]            rem_ff, rem_in;
   pfba_pkg::req_word_type req_ff, req_in;
   logic [1:0]             st_ff, st_in;
   logic [11:0]            base_ff, base_in;
   logic [12:0]            done_ff, done_in;
   logic [XW-1:0]          free_ff, free_in;
   pfba_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [XW-1:0]          m;
   logic [XW-1:0]          len;
   logic [12:0]            step;
   logic [12:0]            rem_inc;

   always_comb begin
      if (XW'(managed_ff) > XW'(FRAMES)) begin
         m = XW'(FRAMES);
      end else begin
         m = XW'(managed_ff);
      end
      len     = XW'(req_ff.run_length);
      step    = (req_ff.align_frames == 13'd0) ? 13'd1 : req_ff.align_frames;
      rem_inc = rem_ff + 13'd1;
   end

   always_comb begin
      status.act        = req_ff.action;
      status.len_zero   = (req_ff.run_length == 13'd0);
      status.dirty      = dirty_ff;
      status.p_at_m     = (p_ff >= m);
      status.p_last     = (p_ff == XW'(FRAMES - 1));
      status.start_fits = ((start_ff + len) <= m);
      status.run_end    = ((p_ff + XW'(1)) == (start_ff + len));
      status.count_done = (done_ff == req_ff.run_length);
      status.bit_used   = rd_ff;
   end

   always_comb begin
      managed_in = managed_ff;
      dirty_in   = dirty_ff;
      p_in       = p_ff;
      start_in   = start_ff;
      rem_in     = rem_ff;
      req_in     = req_ff;
      st_in      = st_ff;
      base_in    = base_ff;
      done_in    = done_ff;
      free_in    = free_ff;
      rsp_in     = rsp_ff;
      we         = 1'b0;
      wd         = 1'b0;
      if (csr_we) begin
         managed_in = csr_data;
         dirty_in   = 1'b1;
      end
      case (cmd.op)
         pfba_pkg::OP_CLEAR: begin
            we   = 1'b1;
            wd   = 1'b0;
            p_in = p_ff + XW'(1);
         end
         pfba_pkg::OP_LOAD: begin
            req_in  = req_word;
            p_in    = '0;
            st_in   = pfba_pkg::ST_OK;
            base_in = '0;
            done_in = '0;
            if (dirty_ff) begin
               free_in = '0;
            end
         end
         pfba_pkg::OP_CNT_EV: begin
            if (!rd_ff) begin
               free_in = free_ff + XW'(1);
            end
            p_in = p_ff + XW'(1);
         end
         pfba_pkg::OP_CNT_FIN: begin
            dirty_in = 1'b0;
         end
         pfba_pkg::OP_PREP: begin
            start_in = '0;
            rem_in   = '0;
            if (req_ff.action == pfba_pkg::ACT_ALLOC) begin
               p_in = '0;
            end else begin
               p_in = XW'(req_ff.frame_index);
            end
         end
         pfba_pkg::OP_ALLOC_EV: begin
            if (!rd_ff) begin
               p_in   = p_ff + XW'(1);
               rem_in = (rem_inc == step) ? 13'd0 : rem_inc;
            end else begin
               start_in = p_ff + XW'(step) - XW'(rem_ff);
               p_in     = p_ff + XW'(step) - XW'(rem_ff);
               rem_in   = '0;
            end
         end
         pfba_pkg::OP_ALLOC_OK: begin
            p_in    = start_ff;
            base_in = start_ff[11:0];
            done_in = req_ff.run_length;
            free_in = free_ff - len;
         end
         pfba_pkg::OP_MARK: begin
            we   = 1'b1;
            wd   = 1'b1;
            p_in = p_ff + XW'(1);
         end
         pfba_pkg::OP_FREE_EV: begin
            if (rd_ff) begin
               we      = 1'b1;
               wd      = 1'b0;
               p_in    = p_ff + XW'(1);
               done_in = done_ff + 13'd1;
               free_in = free_ff + XW'(1);
            end else begin
               st_in = pfba_pkg::ST_ALREADY_FREE;
            end
         end
         pfba_pkg::OP_RES_EV: begin
            if (!rd_ff) begin
               we      = 1'b1;
               wd      = 1'b1;
               done_in = 13'd1;
               free_in = free_ff - XW'(1);
            end
         end
         pfba_pkg::OP_SET_ST: begin
            st_in = cmd.st;
         end
         pfba_pkg::OP_EMIT: begin
            rsp_in.status      = st_ff;
            rsp_in.base_frame  = base_ff;
            rsp_in.frames_done = done_ff;
            rsp_in.free_count  = free_ff[12:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[p_ff[AW-1:0]] <= wd;
      end
      rd_ff <= mem[p_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= 13'(pfba_pkg::MANAGED_RESET);
         dirty_ff   <= 1'b1;
         p_ff       <= '0;
      end else begin
         managed_ff <= managed_in;
         dirty_ff   <= dirty_in;
         p_ff       <= p_in;
      end
      start_ff <= start_in;
      rem_ff   <= rem_in;
      req_ff   <= req_in;
      st_ff    <= st_in;
      base_ff  <= base_in;
      done_ff  <= done_in;
      free_ff  <= free_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_word = rsp_ff;

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pfba_pkg::OP_MARK |-> p_ff < m)
      else $error("Marking a frame outside the managed range.");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pfba_pkg::OP_FREE_EV && rd_ff) |-> p_ff < m)
      else $error("Freeing a frame outside the managed range.");

   a_run_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pfba_pkg::OP_ALLOC_OK |-> (start_ff + len) <= m)
      else $error("Allocated run does not fit below the managed count.");

endmodule

@@ rtl/core/pfba_ctrl.sv @@
// Controller state machine of the allocator, sequencing the datapath for each request word.
module pfba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  pfba_pkg::dp_status_type status,
   output pfba_pkg::dp_cmd_type    cmd,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready
);

   typedef enum logic [17:0] {
      S_CLEAR = 18'b000000000000000001,
      S_IDLE  = 18'b000000000000000010,
      S_PREP  = 18'b000000000000000100,
      S_C_CHK = 18'b000000000000001000,
      S_C_RD  = 18'b000000000000010000,
      S_C_EV  = 18'b000000000000100000,
      S_A_CHK = 18'b000000000001000000,
      S_A_RD  = 18'b000000000010000000,
      S_A_EV  = 18'b000000000100000000,
      S_A_OK  = 18'b000000001000000000,
      S_A_MRK = 18'b000000010000000000,
      S_F_CHK = 18'b000000100000000000,
      S_F_RD  = 18'b000001000000000000,
      S_F_EV  = 18'b000010000000000000,
      S_R_CHK = 18'b000100000000000000,
      S_R_RD  = 18'b001000000000000000,
      S_R_EV  = 18'b010000000000000000,
      S_DONE  = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = pfba_pkg::OP_IDLE;
      cmd.st       = pfba_pkg::ST_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = pfba_pkg::OP_CLEAR;
            if (status.p_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pfba_pkg::OP_LOAD;
               state_in = status.dirty ? S_C_CHK : S_PREP;
            end
         end
         S_C_CHK: begin
            if (status.p_at_m) begin
               cmd.op   = pfba_pkg::OP_CNT_FIN;
               state_in = S_PREP;
            end else begin
               state_in = S_C_RD;
            end
         end
         S_C_RD: begin
            state_in = S_C_EV;
         end
         S_C_EV: begin
            cmd.op   = pfba_pkg::OP_CNT_EV;
            state_in = S_C_CHK;
         end
         S_PREP: begin
            cmd.op = pfba_pkg::OP_PREP;
            if (status.act == pfba_pkg::ACT_ALLOC && !status.len_zero) begin
               state_in = S_A_CHK;
            end else if (status.act == pfba_pkg::ACT_FREE) begin
               state_in = S_F_CHK;
            end else if (status.act == pfba_pkg::ACT_RESERVE) begin
               state_in = S_R_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_A_CHK: begin
            if (!status.start_fits) begin
               cmd.op   = pfba_pkg::OP_SET_ST;
               cmd.st   = pfba_pkg::ST_NO_SPACE;
               state_in = S_DONE;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            state_in = S_A_EV;
         end
         S_A_EV: begin
            cmd.op = pfba_pkg::OP_ALLOC_EV;
            if (status.bit_used) begin
               state_in = S_A_CHK;
            end else if (status.run_end) begin
               state_in = S_A_OK;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_OK: begin
            cmd.op   = pfba_pkg::OP_ALLOC_OK;
            state_in = S_A_MRK;
         end
         S_A_MRK: begin
            cmd.op = pfba_pkg::OP_MARK;
            if (status.run_end) begin
               state_in = S_DONE;
            end
         end
         S_F_CHK: begin
            if (status.count_done) begin
               state_in = S_DONE;
            end else if (status.p_at_m) begin
               cmd.op   = pfba_pkg::OP_SET_ST;
               cmd.st   = pfba_pkg::ST_RANGE;
               state_in = S_DONE;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_F_RD: begin
            state_in = S_F_EV;
         end
         S_F_EV: begin
            cmd.op   = pfba_pkg::OP_FREE_EV;
            state_in = status.bit_used ? S_F_CHK : S_DONE;
         end
         S_R_CHK: begin
            if (status.p_at_m) begin
               cmd.op   = pfba_pkg::OP_SET_ST;
               cmd.st   = pfba_pkg::ST_RANGE;
               state_in = S_DONE;
            end else begin
               state_in = S_R_RD;
            end
         end
         S_R_RD: begin
            state_in = S_R_EV;
         end
         S_R_EV: begin
            cmd.op   = pfba_pkg::OP_RES_EV;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.op       = pfba_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pfba_pkg::OP_EMIT |-> slot_free)
      else $error("Result word loaded while the output register is still full.");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("Request accepted during the clearing pass.");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pfba_pkg::OP_EMIT |=> rsp_valid_ff)
      else $error("Result word loaded without raising valid.");

endmodule
